[design/chroma_blob_mask_centroid_assert.svh]
// assertion macros for the chroma blob mask centroid block
`ifndef CHROMA_BLOB_MASK_CENTROID_ASSERT_SVH
`define CHROMA_BLOB_MASK_CENTROID_ASSERT_SVH
// implication checked every clock outside reset
`define CBMC_ASSERT_IMP(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define CBMC_ASSERT_NXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

[design/cbmc_pkg.sv]
// shared constants and types for the chroma blob mask centroid block
package cbmc_pkg;
    localparam int MAX_COLUMNS = 2048;
    localparam int MAX_ROWS = 2048;
    localparam int COL_W = 11;
    localparam int CNT_W = 23;
    localparam int SUM_W = 33;
    localparam int CEN_W = 15;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] MIN_COUNT_RESET = 23'd50;
    localparam logic [1:0] REG_RED = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BRIGHT = 2'd2;
    localparam logic [1:0] REG_MIN = 2'd3;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int DIV_STEPS = 15;

    // classified word passed from front to back
    typedef struct packed {
        logic             hit;
        logic             last;
        logic [COL_W-1:0] column;
        logic [COL_W-1:0] row;
    } cls_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_OUT
    } bstate_t;
endpackage

[design/cbmc_front.sv]
// front: pixel classification over two pipeline stages
module cbmc_front (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [10:0] column,
    input  logic [10:0] row,
    input  logic        frame_end,
    input  logic [7:0]  red_thr,
    input  logic [7:0]  green_thr,
    input  logic [7:0]  bright_thr,
    output logic        cls_valid,
    input  logic        cls_ready,
    output cbmc_pkg::cls_t cls
);
    localparam int MAX_C = cbmc_pkg::MAX_COLUMNS;
    localparam int MAX_R = cbmc_pkg::MAX_ROWS;

    logic        s1_v_reg;
    logic [7:0]  r_reg, g_reg;
    logic [9:0]  s_reg;
    logic        ok_reg, last_reg;
    logic [10:0] col_reg, row_reg;
    logic [9:0]  s_next;
    logic        adv1;
    logic [9:0]  bright;

    // chroma = min(255, floor((512c+s)/(2s))): compare against thresholds directly
    // rc > t  <=>  512c+s >= 2s(t+1) with t+1 <= 255
    function automatic logic chroma_gt(input logic [7:0] c, input logic [9:0] s,
                                       input logic [7:0] t);
        logic [18:0] lhs;
        logic [18:0] rhs;
        begin
            lhs = {c, 9'd0} + {9'd0, s};
            rhs = {8'd0, s, 1'b0} * ({11'd0, t} + 19'd1);
            chroma_gt = (s != 10'd0) && ((t == 8'hff) ? 1'b0 : (lhs >= rhs));
        end
    endfunction

    assign s_next = {2'd0, red} + {2'd0, green} + {2'd0, blue};
    assign adv1 = !cls_valid || cls_ready;
    assign in_ready = adv1 || !s1_v_reg;
    assign bright = 10'(({22'd0, s_reg} + 32'd1) * 32'd21846 >> 16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            cls_valid <= 1'b0;
        end else begin
            if (adv1) begin
                cls_valid <= s1_v_reg;
            end
            if (in_ready) begin
                s1_v_reg <= in_valid;
            end
        end
        if (in_ready && in_valid) begin
            r_reg <= red;
            g_reg <= green;
            s_reg <= s_next;
            ok_reg <= (32'(column) < MAX_C) && (32'(row) < MAX_R);
            last_reg <= frame_end;
            col_reg <= column;
            row_reg <= row;
        end
        if (adv1 && s1_v_reg) begin
            cls.hit <= ok_reg && chroma_gt(r_reg, s_reg, red_thr)
                && !chroma_gt(g_reg, s_reg, green_thr) && (bright > {2'd0, bright_thr});
            cls.last <= last_reg;
            cls.column <= col_reg;
            cls.row <= row_reg;
        end
    end
endmodule

[design/cbmc_queue.sv]
// short fifo between front and back
module cbmc_queue (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cbmc_pkg::cls_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cbmc_pkg::cls_t rd_data
);
    cbmc_pkg::cls_t mem [cbmc_pkg::QDEPTH];
    logic [cbmc_pkg::QPTR_W-1:0] wp_reg, rp_reg;
    logic [cbmc_pkg::QPTR_W:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 3'(cbmc_pkg::QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
        if (wr) mem[wp_reg] <= wr_data;
    end
endmodule

[design/cbmc_back.sv]
// back: accumulation and frame-end centroid divide
module cbmc_back (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cbmc_pkg::cls_t cls,
    input  logic [22:0] min_count,
    output logic m_valid,
    input  logic m_ready,
    output logic mask_bit,
    output logic frame_done,
    output logic blob_found,
    output logic [22:0] pixel_count,
    output logic [14:0] centroid_x,
    output logic [14:0] centroid_y
);
    cbmc_pkg::bstate_t st_reg, st_next;
    logic [22:0] cnt_reg, cnt_next;
    logic [32:0] cs_reg, rs_reg, cs_next, rs_next;
    logic [33:0] cs_sum, rs_sum;
    logic [3:0]  step_reg;
    logic [37:0] xr_reg, yr_reg;  // remainders
    logic [14:0] xq_reg, yq_reg;
    logic [36:0] xn_reg, yn_reg;  // low 15 bits of sum*16, msb-aligned
    logic [37:0] xt, yt;
    logic        take, found;
    logic        ovx_reg, ovy_reg;

    assign take = in_valid && in_ready;
    assign in_ready = (st_reg == cbmc_pkg::B_IDLE) && (!m_valid || m_ready);
    assign cs_sum = {1'b0, cs_reg} + 34'(cls.column);
    assign rs_sum = {1'b0, rs_reg} + 34'(cls.row);
    assign cnt_next = (cls.hit && cnt_reg != cbmc_pkg::COUNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    assign cs_next = !cls.hit ? cs_reg : (cs_sum[33] ? cbmc_pkg::SUM_MAX : cs_sum[32:0]);
    assign rs_next = !cls.hit ? rs_reg : (rs_sum[33] ? cbmc_pkg::SUM_MAX : rs_sum[32:0]);
    assign found = cnt_next > min_count;
    // restoring division: quotient saturates, so start at bit 14 with a pre-check
    assign xt = {xr_reg[36:0], xn_reg[36]};
    assign yt = {yr_reg[36:0], yn_reg[36]};

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            cbmc_pkg::B_IDLE: if (take && cls.last && found) st_next = cbmc_pkg::B_DIV;
            cbmc_pkg::B_DIV: if (step_reg == 4'd0) st_next = cbmc_pkg::B_OUT;
            cbmc_pkg::B_OUT: st_next = cbmc_pkg::B_IDLE;
            default: st_next = cbmc_pkg::B_IDLE;
        endcase
    end

    logic [37:0] den;
    logic [37:0] xd, yd;
    assign den = {15'd0, pixel_count};
    assign xd = xt - den;
    assign yd = yt - den;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= cbmc_pkg::B_IDLE;
            m_valid <= 1'b0;
            cnt_reg <= '0;
            cs_reg <= '0;
            rs_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (st_reg == cbmc_pkg::B_OUT) m_valid <= 1'b1;
            if (take) begin
                if (!(cls.last && found)) m_valid <= 1'b1;
                if (cls.last) begin
                    cnt_reg <= '0;
                    cs_reg <= '0;
                    rs_reg <= '0;
                end else begin
                    cnt_reg <= cnt_next;
                    cs_reg <= cs_next;
                    rs_reg <= rs_next;
                end
            end
        end
        if (take) begin
            mask_bit <= cls.hit;
            frame_done <= cls.last;
            blob_found <= cls.last && found;
            pixel_count <= cls.last ? cnt_next : '0;
            centroid_x <= '0;
            centroid_y <= '0;
            // shift out 22 leading bits at once: they give quotient above 2^15 only via check
            xn_reg <= {cs_next, 4'd0} << 22;
            yn_reg <= {rs_next, 4'd0} << 22;
            xr_reg <= 38'({cs_next, 4'd0} >> 15);
            yr_reg <= 38'({rs_next, 4'd0} >> 15);
            step_reg <= 4'(cbmc_pkg::DIV_STEPS - 1);
            xq_reg <= '0;
            yq_reg <= '0;
        end
        if (st_reg == cbmc_pkg::B_DIV) begin
            if (!xd[37]) begin xr_reg <= xd; xq_reg <= {xq_reg[13:0], 1'b1}; end
            else begin xr_reg <= xt; xq_reg <= {xq_reg[13:0], 1'b0}; end
            if (!yd[37]) begin yr_reg <= yd; yq_reg <= {yq_reg[13:0], 1'b1}; end
            else begin yr_reg <= yt; yq_reg <= {yq_reg[13:0], 1'b0}; end
            xn_reg <= {xn_reg[35:0], 1'b0};
            yn_reg <= {yn_reg[35:0], 1'b0};
            step_reg <= step_reg - 1'b1;
        end
        if (st_reg == cbmc_pkg::B_OUT) begin
            centroid_x <= ovx_reg ? 15'h7fff : xq_reg;
            centroid_y <= ovy_reg ? 15'h7fff : yq_reg;
        end
    end

    // high part >= count means quotient >= 2^15: saturate
    always_ff @(posedge aclk) begin
        if (take) begin
            ovx_reg <= (38'({cs_next, 4'd0} >> 15)) >= {15'd0, cnt_next};
            ovy_reg <= (38'({rs_next, 4'd0} >> 15)) >= {15'd0, cnt_next};
        end
    end
endmodule

[design/chroma_blob_mask_centroid.sv]
// top level of the chroma blob mask centroid block
// Pixels enter at up to one word per clock. A two-stage front computes the
// chromaticity and brightness tests and the mask bit; a four-entry queue feeds
// the back, which accumulates one word per clock while its output is accepted.
// A frame-end word that finds a blob holds the back while per-axis bit-serial
// dividers produce both centroids (one quotient bit of each per cycle); no
// other word holds it. Results wait in an output register.
`include "chroma_blob_mask_centroid_assert.svh"
module chroma_blob_mask_centroid (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [10:0] s_column,
    input  logic [10:0] s_row,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_mask_bit,
    output logic        m_frame_done,
    output logic        m_blob_found,
    output logic [22:0] m_pixel_count,
    output logic [14:0] m_centroid_x,
    output logic [14:0] m_centroid_y
);
    // threshold registers
    logic [7:0]  red_thr_reg, green_thr_reg, bright_thr_reg;
    logic [22:0] min_cnt_reg;
    logic        fq_valid, fq_ready, qb_valid, qb_ready;
    cbmc_pkg::cls_t fq_data, qb_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_thr_reg <= '0;
            green_thr_reg <= '0;
            bright_thr_reg <= '0;
            min_cnt_reg <= cbmc_pkg::MIN_COUNT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cbmc_pkg::REG_RED: red_thr_reg <= cfg_data[7:0];
                cbmc_pkg::REG_GREEN: green_thr_reg <= cfg_data[7:0];
                cbmc_pkg::REG_BRIGHT: bright_thr_reg <= cfg_data[7:0];
                cbmc_pkg::REG_MIN: min_cnt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // classification front
    cbmc_front u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .red(s_red), .green(s_green), .blue(s_blue), .column(s_column),
        .row(s_row), .frame_end(s_frame_end), .red_thr(red_thr_reg),
        .green_thr(green_thr_reg), .bright_thr(bright_thr_reg),
        .cls_valid(fq_valid), .cls_ready(fq_ready), .cls(fq_data)
    );

    // decoupling queue
    cbmc_queue u_queue (
        .aclk, .aresetn, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
    );

    // accumulate and divide
    cbmc_back u_back (
        .aclk, .aresetn, .in_valid(qb_valid), .in_ready(qb_ready), .cls(qb_data),
        .min_count(min_cnt_reg), .m_valid, .m_ready, .mask_bit(m_mask_bit),
        .frame_done(m_frame_done), .blob_found(m_blob_found),
        .pixel_count(m_pixel_count), .centroid_x(m_centroid_x),
        .centroid_y(m_centroid_y)
    );

    `CBMC_ASSERT_IMP(a_found_at_end, aclk, aresetn, m_valid && m_blob_found, m_frame_done)
    `CBMC_ASSERT_IMP(a_count_at_end, aclk, aresetn, m_valid && !m_frame_done,
        m_pixel_count == '0)
    `CBMC_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule
